[rtl/dops_pkg.sv]
`timescale 1ns / 1ps

package dops_pkg;

    localparam int VEC_LEN_DEF = 16;
    localparam int HEADS_DEF   = 8;
    localparam int LAYERS_DEF  = 4;

    localparam int NUM_DECAY = 4;
    localparam int DEC_IW    = $clog2(NUM_DECAY);
    localparam int CFG_IDX_W = 4;
    localparam logic [15:0] DECAY_RST = 16'hFFFF;

    localparam int WIDE_W    = 50;
    localparam int DEC_SHIFT = 16;
    localparam int KV_SHIFT  = 8;
    localparam int QS_SHIFT  = 12;

    typedef logic signed [15:0]       t_fix16;
    typedef logic signed [31:0]       t_fix32;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [15:0]              t_ratio;

    // round to nearest, ties toward plus infinity, then arithmetic shift
    function automatic t_wide f_round_shr(input t_wide x, input int sh);
        t_wide b;
        b = x + (t_wide'(1) <<< (sh - 1));
        return b >>> sh;
    endfunction

    function automatic t_fix32 f_sat32(input t_wide x);
        logic [WIDE_W-32:0] hi;
        hi = x[WIDE_W-1:31];
        if ((&hi) || !(|hi)) begin
            return x[31:0];
        end else if (x[WIDE_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

[rtl/decayed_outer_product_state_update_top.sv]
`timescale 1ns / 1ps

// Decayed outer-product state update. One VEC_LEN x VEC_LEN Q16.16 state matrix per
// layer and head lives in a single-port-read synchronous memory; a row item walks its
// VEC_LEN columns through that memory one column a cycle, doing the decay-multiply-add,
// writing the new state back and adding q times it into a column accumulator. After
// reset the state memory is zeroed one entry at a time, LAYERS*HEADS*VEC_LEN*VEC_LEN
// entries (8192 at the defaults), during which no item is taken; configuration writes
// are always taken. A row item does one state read per cycle through a four-stage
// multiply pipeline, and no item is taken until that pipeline has drained. The row
// VEC_LEN-1 item then reads the VEC_LEN results out of the accumulator at one per cycle
// while the two-entry output queue has room, and no item is taken until that readout
// ends; queued results drain while the next item runs.
module decayed_outer_product_state_update_top #(
    parameter int VEC_LEN  = dops_pkg::VEC_LEN_DEF,
    parameter int HEADS    = dops_pkg::HEADS_DEF,
    parameter int LAYERS   = dops_pkg::LAYERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dops_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [1:0]                       i_layer,
    input  logic [2:0]                       i_head,
    input  logic [3:0]                       i_index,
    input  logic signed [15:0]               i_v_value,
    input  logic signed [15:0]               i_k_value,
    input  logic signed [15:0]               i_q_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_out_layer,
    output logic [2:0]                       o_out_head,
    output logic [3:0]                       o_column,
    output logic signed [31:0]               o_value,
    output logic                             o_last
);
    import dops_pkg::*;

    localparam int DW       = $clog2(VEC_LEN);
    localparam int ST_DEPTH = LAYERS * HEADS * VEC_LEN * VEC_LEN;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int STRIDE_H = VEC_LEN * VEC_LEN;
    localparam int STRIDE_L = HEADS * STRIDE_H;
    localparam int P_DEC_W  = 49;
    localparam int P_KV_W   = 32;
    localparam int P_QS_W   = 48;

    typedef struct packed {
        logic [1:0] layer;
        logic [2:0] head;
        logic [3:0] column;
        t_fix32     value;
        logic       last;
    } t_out_item;

    // configuration
    t_ratio r_decay [NUM_DECAY];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DECAY; i++) begin
                r_decay[i] <= DECAY_RST;
            end
        end else if (i_cfg_valid && o_cfg_ready && (int'(i_cfg_index) < NUM_DECAY)) begin
            r_decay[DEC_IW'(i_cfg_index)] <= i_cfg_data;
        end
    end

    // input acceptance
    logic w_clearing;
    logic w_in_acc;
    logic w_row_ok;
    logic w_sel_ok;
    logic w_start;
    logic w_load;

    logic             r_issue_act;
    logic [DW-1:0]    r_col;
    logic             r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [DW-1:0]    r_s1_col, r_s2_col, r_s3_col, r_s4_col;
    logic             r_emit_act;
    logic [DW-1:0]    r_emit_col;

    assign o_in_stall = w_clearing || r_issue_act || r_s1_vld || r_s2_vld
                     || r_s3_vld || r_s4_vld || r_emit_act;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_row_ok = int'(i_index) < VEC_LEN;
    assign w_sel_ok = (int'(i_layer) < LAYERS) && (int'(i_head) < HEADS);
    assign w_start  = w_in_acc && i_mode && w_row_ok && w_sel_ok;
    assign w_load   = w_in_acc && !i_mode && w_row_ok;

    // per-row context
    logic [ST_AW-1:0] r_base;
    t_fix16           r_k;
    t_fix16           r_q;
    t_ratio           r_ratio;
    logic             r_row0;
    logic             r_lastrow;
    logic [1:0]       r_layer;
    logic [2:0]       r_head;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_base    <= ST_AW'(int'(i_layer) * STRIDE_L + int'(i_head) * STRIDE_H
                              + int'(i_index) * VEC_LEN);
            r_k       <= i_k_value;
            r_q       <= i_q_value;
            r_ratio   <= r_decay[i_layer];
            r_row0    <= (i_index == '0);
            r_lastrow <= (int'(i_index) == VEC_LEN - 1);
            r_layer   <= i_layer;
            r_head    <= i_head;
        end
    end

    // column sequencer and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_act <= 1'b0;
            r_col       <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
        end else begin
            if (w_start) begin
                r_issue_act <= 1'b1;
                r_col       <= '0;
            end else if (r_issue_act) begin
                r_col <= r_col + 1'b1;
                if (r_col == DW'(VEC_LEN - 1)) begin
                    r_issue_act <= 1'b0;
                end
            end
            r_s1_vld <= r_issue_act;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col <= r_col;
        r_s2_col <= r_s1_col;
        r_s3_col <= r_s2_col;
        r_s4_col <= r_s3_col;
    end

    // value buffer
    t_fix16 r_vbuf [VEC_LEN];
    t_fix16 r_vb_rd;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_vbuf[DW'(i_index)] <= i_v_value;
        end
        if (r_issue_act) begin
            r_vb_rd <= r_vbuf[r_col];
        end
    end

    // state memory
    t_fix32 w_st_rd;
    t_fix32 w_ns;

    dops_state_mem #(
        .DEPTH (ST_DEPTH)
    ) u_state_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (r_issue_act),
        .i_rd_addr  (r_base + ST_AW'(r_col)),
        .o_rd_data  (w_st_rd),
        .i_wr_en    (r_s2_vld),
        .i_wr_addr  (r_base + ST_AW'(r_s2_col)),
        .i_wr_data  (w_ns),
        .o_clearing (w_clearing)
    );

    // stage 1: decay and key-value products
    logic signed [16:0]        w_ratio_s;
    logic signed [P_DEC_W-1:0] r_p_dec;
    logic signed [P_KV_W-1:0]  r_p_kv;

    assign w_ratio_s = {1'b0, r_ratio};

    always_ff @(posedge i_clk) begin
        r_p_dec <= P_DEC_W'(w_ratio_s) * P_DEC_W'(w_st_rd);
        r_p_kv  <= P_KV_W'(r_k) * P_KV_W'(r_vb_rd);
    end

    // stage 2: round, sum, saturate, write back
    t_wide  w_dec;
    t_wide  w_kv;
    t_fix32 r_ns;

    assign w_dec = f_round_shr(t_wide'(r_p_dec), DEC_SHIFT);
    assign w_kv  = f_round_shr(t_wide'(r_p_kv), KV_SHIFT);
    assign w_ns  = f_sat32(w_dec + w_kv);

    always_ff @(posedge i_clk) begin
        r_ns <= w_ns;
    end

    // stage 3: query product
    logic signed [P_QS_W-1:0] r_p_qs;

    always_ff @(posedge i_clk) begin
        r_p_qs <= P_QS_W'(r_q) * P_QS_W'(r_ns);
    end

    // stage 4: accumulate
    t_wide   w_qs;
    t_fix32  w_acc_rd;
    t_fix32  w_acc_new;
    logic    w_emit_rd;
    logic    w_acc_rd_en;
    logic [DW-1:0] w_acc_rd_addr;

    assign w_qs      = f_round_shr(t_wide'(r_p_qs), QS_SHIFT);
    assign w_acc_new = r_row0 ? f_sat32(w_qs) : f_sat32(t_wide'(w_acc_rd) + w_qs);

    assign w_acc_rd_en   = r_s3_vld || w_emit_rd;
    assign w_acc_rd_addr = r_s3_vld ? r_s3_col : r_emit_col;

    dops_acc_mem #(
        .DEPTH (VEC_LEN)
    ) u_acc_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc_rd_en),
        .i_rd_addr (w_acc_rd_addr),
        .o_rd_data (w_acc_rd),
        .i_wr_en   (r_s4_vld),
        .i_wr_addr (r_s4_col),
        .i_wr_data (w_acc_new)
    );

    // result readout into a two-entry queue
    logic          r_inflight;
    logic [DW-1:0] r_if_col;
    logic          r_if_last;
    t_out_item     r_fq [2];
    logic          r_fq_wp;
    logic          r_fq_rp;
    logic [1:0]    r_fq_cnt;
    logic          w_pop;
    logic [2:0]    w_occ;
    logic          w_emit_go;

    assign w_pop     = o_out_valid && !i_out_stall;
    assign w_occ     = 3'(r_fq_cnt) + 3'(r_inflight) - 3'(w_pop);
    assign w_emit_rd = r_emit_act && (w_occ < 3'd2);
    assign w_emit_go = r_s4_vld && (r_s4_col == DW'(VEC_LEN - 1)) && r_lastrow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_act <= 1'b0;
            r_emit_col <= '0;
            r_inflight <= 1'b0;
            r_fq_wp    <= 1'b0;
            r_fq_rp    <= 1'b0;
            r_fq_cnt   <= '0;
        end else begin
            if (w_emit_go) begin
                r_emit_act <= 1'b1;
                r_emit_col <= '0;
            end else if (w_emit_rd) begin
                r_emit_col <= r_emit_col + 1'b1;
                if (r_emit_col == DW'(VEC_LEN - 1)) begin
                    r_emit_act <= 1'b0;
                end
            end
            r_inflight <= w_emit_rd;
            if (r_inflight) begin
                r_fq_wp <= !r_fq_wp;
            end
            if (w_pop) begin
                r_fq_rp <= !r_fq_rp;
            end
            r_fq_cnt <= r_fq_cnt + 2'(r_inflight) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_if_col  <= r_emit_col;
        r_if_last <= (r_emit_col == DW'(VEC_LEN - 1));
        if (r_inflight) begin
            r_fq[r_fq_wp] <= '{layer:  r_layer,
                               head:   r_head,
                               column: 4'(r_if_col),
                               value:  w_acc_rd,
                               last:   r_if_last};
        end
    end

    assign o_out_valid = (r_fq_cnt != '0);
    assign o_out_layer = r_fq[r_fq_rp].layer;
    assign o_out_head  = r_fq[r_fq_rp].head;
    assign o_column    = r_fq[r_fq_rp].column;
    assign o_value     = r_fq[r_fq_rp].value;
    assign o_last      = r_fq[r_fq_rp].last;

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_act |-> !(r_issue_act || r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld))
        else $error("readout overlaps row processing");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> ((r_fq_cnt != 2'd2) || w_pop))
        else $error("result queue overflow");

    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !(r_issue_act || r_s2_vld || r_s4_vld))
        else $error("state access during zeroing sweep");

    a_readout_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight && r_if_last) |=> !r_emit_act)
        else $error("readout continues past last column");

endmodule

[rtl/dops_state_mem.sv]
`timescale 1ns / 1ps

module dops_state_mem #(
    parameter int DEPTH = dops_pkg::LAYERS_DEF * dops_pkg::HEADS_DEF
                        * dops_pkg::VEC_LEN_DEF * dops_pkg::VEC_LEN_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output dops_pkg::t_fix32     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  dops_pkg::t_fix32     i_wr_data,
    output logic                 o_clearing
);
    import dops_pkg::*;

    t_fix32        r_mem [DEPTH];
    t_fix32        r_rd;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          w_we;
    logic [AW-1:0] w_wa;
    t_fix32        w_wd;

    assign w_we = r_clearing || i_wr_en;
    assign w_wa = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_wd = r_clearing ? '0 : i_wr_data;

    // zeroing sweep after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd;
    assign o_clearing = r_clearing;

endmodule

[rtl/dops_acc_mem.sv]
`timescale 1ns / 1ps

module dops_acc_mem #(
    parameter int DEPTH = dops_pkg::VEC_LEN_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output dops_pkg::t_fix32 o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  dops_pkg::t_fix32 i_wr_data
);
    import dops_pkg::*;

    t_fix32     r_mem [DEPTH];
    logic       r_vld [DEPTH];
    t_fix32     r_rd;
    logic       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule
